>>> rtl/tvp_pkg.sv
// shared types and constants of the tile video processor
`timescale 1ns / 1ps
`default_nettype none

package tvp_pkg;

   // request command codes
   localparam logic [2:0] CMD_CTRL_WRITE = 3'd0;
   localparam logic [2:0] CMD_CTRL_READ  = 3'd1;
   localparam logic [2:0] CMD_DATA_WRITE = 3'd2;
   localparam logic [2:0] CMD_DATA_READ  = 3'd3;
   localparam logic [2:0] CMD_PIXEL      = 3'd4;

   // classified operation codes handed to the back end
   localparam logic [2:0] OP_CTRL_WRITE = 3'd0;
   localparam logic [2:0] OP_DATA_WRITE = 3'd1;
   localparam logic [2:0] OP_DATA_READ  = 3'd2;
   localparam logic [2:0] OP_PIXEL      = 3'd3;
   localparam logic [2:0] OP_NONE       = 3'd4;

   localparam logic [13:0] NAME_TABLE_BASE = 14'h3800;
   localparam logic [14:0] PALETTE_BASE    = 15'h4000;

   localparam logic [1:0] CTRL_SEL_REG     = 2'b10;
   localparam logic [1:0] CTRL_SEL_PALETTE = 2'b11;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  value;
      logic [13:0] entry_addr;
      logic [2:0]  tile_row;
      logic [2:0]  bit_sel;
   } tvp_op_type;

   typedef struct packed {
      logic       valid;
      tvp_op_type op;
   } tvp_op_chan_type;

   typedef struct packed {
      logic take;
      logic clearing;
   } tvp_back_status_type;

endpackage

`default_nettype wire

>>> rtl/tvp_front.sv
// front end: accepts request transactions, classifies them, queues operations
`timescale 1ns / 1ps
`default_nettype none

module tvp_front #(
   parameter int SCREEN_WIDTH  = 256,
   parameter int SCREEN_HEIGHT = 192
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         push,
   output logic                              full,
   input  wire logic [2:0]                   req_cmd,
   input  wire logic [7:0]                   req_value,
   input  wire logic [8:0]                   req_pixel_x,
   input  wire logic [7:0]                   req_pixel_y,
   output tvp_pkg::tvp_op_chan_type          op_chan,
   input  wire tvp_pkg::tvp_back_status_type back_status
);
   import tvp_pkg::*;

   tvp_op_type q_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] count_ff, count_in;
   tvp_op_type op_new;
   logic       on_screen;
   logic       accept;
   logic       take;

   assign on_screen = (req_pixel_x < 9'(SCREEN_WIDTH)) &&
                      ({1'b0, req_pixel_y} < 9'(SCREEN_HEIGHT));

   always_comb begin
      op_new.value      = req_value;
      op_new.entry_addr = NAME_TABLE_BASE |
                          {3'b000, req_pixel_y[7:3], req_pixel_x[7:3], 1'b0};
      op_new.tile_row   = req_pixel_y[2:0];
      op_new.bit_sel    = req_pixel_x[2:0];
      case (req_cmd)
         CMD_CTRL_WRITE: op_new.kind = OP_CTRL_WRITE;
         CMD_CTRL_READ:  op_new.kind = OP_NONE;
         CMD_DATA_WRITE: op_new.kind = OP_DATA_WRITE;
         CMD_DATA_READ:  op_new.kind = OP_DATA_READ;
         CMD_PIXEL:      op_new.kind = on_screen ? OP_PIXEL : OP_NONE;
         default:        op_new.kind = OP_NONE;
      endcase
   end

   assign full   = (count_ff == 2'd2) || back_status.clearing;
   assign accept = push && !full;
   assign take   = back_status.take && (count_ff != 2'd0);

   assign op_chan.valid = (count_ff != 2'd0);
   assign op_chan.op    = q_ff[rd_ff];

   always_comb begin
      wr_in    = accept ? ~wr_ff : wr_ff;
      rd_in    = take ? ~rd_ff : rd_ff;
      count_in = count_ff + {1'b0, accept} - {1'b0, take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ff] <= op_new;
      end
   end

endmodule

`default_nettype wire

>>> rtl/tvp_back.sv
// back end: video memory, port state, pixel sequencer and result queue
`timescale 1ns / 1ps
`default_nettype none

module tvp_back #(
   parameter int MEMORY_BYTES = 16416
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire tvp_pkg::tvp_op_chan_type op_chan,
   output tvp_pkg::tvp_back_status_type  back_status,
   output logic                          empty,
   input  wire logic                     pop,
   output logic [7:0]                    rsp_read_byte
);
   import tvp_pkg::*;

   localparam int AW = $clog2(MEMORY_BYTES + 1);
   localparam int MI = $clog2(MEMORY_BYTES);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_READ  = 4'd2;
   localparam logic [3:0] S_E0    = 4'd3;
   localparam logic [3:0] S_E1    = 4'd4;
   localparam logic [3:0] S_T0    = 4'd5;
   localparam logic [3:0] S_T1    = 4'd6;
   localparam logic [3:0] S_T2    = 4'd7;
   localparam logic [3:0] S_T3    = 4'd8;
   localparam logic [3:0] S_PAL   = 4'd9;

   logic [7:0]    mem_array [MEMORY_BYTES];
   logic [7:0]    rdata_ff;

   logic [3:0]    state_ff, state_in;
   logic [MI-1:0] clear_ff, clear_in;
   logic [AW-1:0] access_ff, access_in;
   logic [7:0]    latched_ff, latched_in;
   logic          pending_ff, pending_in;
   logic [7:0]    ctrl_ff [16];
   tvp_op_type    op_ff, op_in;
   logic [7:0]    entry_lo_ff, entry_lo_in;
   logic [13:0]   tile_ff, tile_in;
   logic          palsel_ff, palsel_in;
   logic [2:0]    index_ff, index_in;

   logic          ctrl_we;
   logic          mem_we, mem_re;
   logic [MI-1:0] mem_wa, mem_ra;
   logic [7:0]    mem_wd;
   logic          take;
   logic          res_push;
   logic [7:0]    res_data;
   logic          plane_bit;
   logic [13:0]   tile_base;
   logic          at_end;

   // result queue
   logic [7:0]    rq_ff [2];
   logic          rq_wr_ff, rq_rd_ff;
   logic [1:0]    rq_count_ff;
   logic          rq_pop;

   assign plane_bit = rdata_ff[~op_ff.bit_sel];
   assign tile_base = {rdata_ff[0], entry_lo_ff, op_ff.tile_row, 2'b00};
   assign at_end    = (access_ff == AW'(MEMORY_BYTES));

   always_comb begin
      state_in    = state_ff;
      clear_in    = clear_ff;
      access_in   = access_ff;
      latched_in  = latched_ff;
      pending_in  = pending_ff;
      op_in       = op_ff;
      entry_lo_in = entry_lo_ff;
      tile_in     = tile_ff;
      palsel_in   = palsel_ff;
      index_in    = index_ff;
      ctrl_we     = 1'b0;
      mem_we      = 1'b0;
      mem_wa      = access_ff[MI-1:0];
      mem_wd      = op_chan.op.value;
      mem_re      = 1'b0;
      mem_ra      = access_ff[MI-1:0];
      take        = 1'b0;
      res_push    = 1'b0;
      res_data    = 8'd0;
      case (state_ff)
         S_CLEAR: begin
            mem_we   = 1'b1;
            mem_wa   = clear_ff;
            mem_wd   = 8'd0;
            clear_in = clear_ff + MI'(1);
            if (clear_ff == MI'(MEMORY_BYTES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (op_chan.valid && (rq_count_ff != 2'd2)) begin
               take  = 1'b1;
               op_in = op_chan.op;
               case (op_chan.op.kind)
                  OP_CTRL_WRITE: begin
                     res_push = 1'b1;
                     if (!pending_ff) begin
                        latched_in = op_chan.op.value;
                        pending_in = 1'b1;
                     end else begin
                        pending_in = 1'b0;
                        case (op_chan.op.value[7:6])
                           CTRL_SEL_REG:     ctrl_we = 1'b1;
                           CTRL_SEL_PALETTE: access_in =
                              AW'(PALETTE_BASE | {10'd0, latched_ff[4:0]});
                           default:          access_in =
                              AW'({op_chan.op.value[5:0], latched_ff});
                        endcase
                     end
                  end
                  OP_DATA_WRITE: begin
                     res_push = 1'b1;
                     if (!at_end) begin
                        mem_we    = 1'b1;
                        access_in = access_ff + AW'(1);
                     end
                  end
                  OP_DATA_READ: begin
                     if (at_end) begin
                        res_push = 1'b1;
                     end else begin
                        mem_re    = 1'b1;
                        access_in = access_ff + AW'(1);
                        state_in  = S_READ;
                     end
                  end
                  OP_PIXEL: begin
                     mem_re   = 1'b1;
                     mem_ra   = MI'(op_chan.op.entry_addr);
                     state_in = S_E0;
                  end
                  default: res_push = 1'b1;
               endcase
            end
         end
         S_READ: begin
            res_push = 1'b1;
            res_data = rdata_ff;
            state_in = S_IDLE;
         end
         S_E0: begin
            entry_lo_in = rdata_ff;
            mem_re      = 1'b1;
            mem_ra      = MI'(op_ff.entry_addr | 14'd1);
            state_in    = S_E1;
         end
         S_E1: begin
            palsel_in = rdata_ff[3];
            tile_in   = tile_base;
            mem_re    = 1'b1;
            mem_ra    = MI'(tile_base);
            state_in  = S_T0;
         end
         S_T0: begin
            index_in[0] = plane_bit;
            mem_re      = 1'b1;
            mem_ra      = MI'(tile_ff | 14'd1);
            state_in    = S_T1;
         end
         S_T1: begin
            index_in[1] = plane_bit;
            mem_re      = 1'b1;
            mem_ra      = MI'(tile_ff | 14'd2);
            state_in    = S_T2;
         end
         S_T2: begin
            index_in[2] = plane_bit;
            mem_re      = 1'b1;
            mem_ra      = MI'(tile_ff | 14'd3);
            state_in    = S_T3;
         end
         S_T3: begin
            mem_re   = 1'b1;
            mem_ra   = MI'(PALETTE_BASE | {10'd0, palsel_ff, plane_bit, index_ff});
            state_in = S_PAL;
         end
         S_PAL: begin
            res_push = 1'b1;
            res_data = rdata_ff;
            state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clear_ff   <= '0;
         access_ff  <= '0;
         latched_ff <= 8'd0;
         pending_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clear_ff   <= clear_in;
         access_ff  <= access_in;
         latched_ff <= latched_in;
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      entry_lo_ff <= entry_lo_in;
      tile_ff     <= tile_in;
      palsel_ff   <= palsel_in;
      index_ff    <= index_in;
   end

   // control registers are kept but drive nothing
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            ctrl_ff[i] <= 8'd0;
         end
      end else if (ctrl_we) begin
         ctrl_ff[op_chan.op.value[3:0]] <= latched_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_array[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rdata_ff <= mem_array[mem_ra];
      end
   end

   assign back_status.take     = take;
   assign back_status.clearing = (state_ff == S_CLEAR);

   assign rq_pop        = pop && (rq_count_ff != 2'd0);
   assign empty         = (rq_count_ff == 2'd0);
   assign rsp_read_byte = rq_ff[rq_rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff    <= 1'b0;
         rq_rd_ff    <= 1'b0;
         rq_count_ff <= 2'd0;
      end else begin
         if (res_push) begin
            rq_wr_ff <= ~rq_wr_ff;
         end
         if (rq_pop) begin
            rq_rd_ff <= ~rq_rd_ff;
         end
         rq_count_ff <= rq_count_ff + {1'b0, res_push} - {1'b0, rq_pop};
      end
   end

   always_ff @(posedge clock) begin
      if (res_push) begin
         rq_ff[rq_wr_ff] <= res_data;
      end
   end

endmodule

`default_nettype wire

>>> rtl/tile_video_processor_ports.sv
// top level of the tile video processor with its command, data and pixel ports
//
// request side is a queue: a transaction enters on a clock edge with push high
// and full low, carrying req_cmd, req_value, req_pixel_x and req_pixel_y
// result side is a queue too: rsp_read_byte is valid while empty is low and
// leaves on a clock edge with pop high; every request gives exactly one result
// the front end classifies requests and holds up to two operations, the back
// end owns the single-port video memory and runs them one at a time
// command writes, data writes and zero results are pushed to the result queue
// as the back end takes them, data reads after a read state, pixel queries
// after seven serial reads of the one memory port; the back end takes a new
// operation only when idle and the result queue has room
// after reset a clearing pass zeroes the memory at one byte a cycle, so full
// stays high until the pass ends; queues, address and latch are cleared
// a stalled receiver fills the two-entry result queue, then the operation
// queue, and full rises; nothing is dropped
`timescale 1ns / 1ps
`default_nettype none

module tile_video_processor_ports #(
   parameter int MEMORY_BYTES  = 16416,
   parameter int SCREEN_WIDTH  = 256,
   parameter int SCREEN_HEIGHT = 192
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   output logic            full,
   input  wire logic [2:0] req_cmd,
   input  wire logic [7:0] req_value,
   input  wire logic [8:0] req_pixel_x,
   input  wire logic [7:0] req_pixel_y,
   output logic            empty,
   input  wire logic       pop,
   output logic [7:0]      rsp_read_byte
);
   import tvp_pkg::*;

   // classified operations towards the back end
   tvp_op_chan_type     op_chan;
   // take strobe and clearing flag back to the front end
   tvp_back_status_type back_status;

   tvp_front #(
      .SCREEN_WIDTH (SCREEN_WIDTH),
      .SCREEN_HEIGHT(SCREEN_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_cmd    (req_cmd),
      .req_value  (req_value),
      .req_pixel_x(req_pixel_x),
      .req_pixel_y(req_pixel_y),
      .op_chan    (op_chan),
      .back_status(back_status)
   );

   // memory, port state and pixel sequencer
   tvp_back #(
      .MEMORY_BYTES(MEMORY_BYTES)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .op_chan      (op_chan),
      .back_status  (back_status),
      .empty        (empty),
      .pop          (pop),
      .rsp_read_byte(rsp_read_byte)
   );

endmodule

`default_nettype wire
